[hdl/stwm_pkg.sv]
package stwm_pkg;

  localparam int SIDE    = 7;
  localparam int HALF    = SIDE / 2;
  localparam int NSLOTS  = SIDE * SIDE;
  localparam int COORD_W = 20;
  localparam int SLOT_W  = 6;
  localparam int IDX_W   = $clog2(NSLOTS);
  localparam int CNT_W   = $clog2(NSLOTS + 1);
  localparam int OFS_W   = $clog2(SIDE);
  localparam int OV_W    = $clog2(SIDE + 1);

  localparam logic [COORD_W-1:0] COORD_MAX = '1;
  localparam logic [COORD_W-1:0] HALF_C    = COORD_W'(HALF);

  typedef enum logic {
    FUNC_MOVE   = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_e;

  typedef enum logic {
    KIND_MOVE   = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  typedef struct packed {
    func_e              func;
    logic [COORD_W-1:0] tile_col;
    logic [COORD_W-1:0] tile_row;
  } req_word_t;

  typedef struct packed {
    kind_e              kind;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] new_col;
    logic [COORD_W-1:0] new_row;
    logic               found;
    logic               last;
  } rsp_word_t;

endpackage

[hdl/stwm_ram.sv]
module stwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/stwm_out.sv]
module stwm_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  stwm_pkg::rsp_word_t word,
  output logic              free,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output stwm_pkg::rsp_word_t rsp
);

  import stwm_pkg::*;

  assign free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= word;
    end
  end

endmodule

[hdl/sliding_tile_window_manager.sv]
// Channel | Direction | Handshake            | Word
// req     | in        | req_valid/req_ready  | req_word_t: func, tile_col, tile_row
// rsp     | out       | rsp_valid/rsp_ready  | rsp_word_t: kind, slot, new_col, new_row,
//         |           |                      |   found, last
// One word at a time. A lookup walks the slot RAM, one slot a cycle, until a hit or the last slot.
// A move walks the slot RAM once, freeing every slot not held inside the new window, then
// walks the new window: a position already held is skipped, one that is assigned takes a slot.
// An ignored move gives no rsp word. Each RAM has a single read port.
// Reset clears all slots through per-slot valid bits at once; no clearing pass.
// A stalled rsp holds the sequencer; req is taken again once the sequencer is idle.
module sliding_tile_window_manager (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  stwm_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output stwm_pkg::rsp_word_t rsp
);

  import stwm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_POS,
    S_EMIT,
    S_LOOK,
    S_LRES
  } state_t;

  state_t             state;
  logic [COORD_W-1:0] x0, y0;
  logic [COORD_W-1:0] cen_col, cen_row;
  logic               cen_vld;
  logic [NSLOTS-1:0]  vld;
  logic [CNT_W-1:0]   cnt;
  logic               chk_vld;
  logic [IDX_W-1:0]   chk_idx;
  logic [CNT_W-1:0]   nfree, take;
  logic [OFS_W-1:0]   dx, dy, dx_next, dy_next;
  logic [OV_W-1:0]    ox, oy;
  logic               found_r;
  logic [IDX_W-1:0]   fslot;

  logic [2*COORD_W-1:0] slot_rdata;
  logic [COORD_W-1:0]   sc, sr;
  logic [IDX_W-1:0]     fr_rdata;
  logic                 slot_we, free_we;
  logic [COORD_W-1:0]   wlo_x, whi_x, wlo_y, whi_y, px, py;
  logic                 keep, hit, old_in, fresh, pos_end, is_last;
  logic [CNT_W-1:0]     ovl, n_new, n_tot;
  logic                 out_free, load;
  rsp_word_t            word;
  logic [COORD_W-1:0]   dcol, drow;
  logic [OV_W-1:0]      ox_next, oy_next;
  logic                 ignore;

  stwm_ram #(.WIDTH(2 * COORD_W), .DEPTH(NSLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (fr_rdata),
    .wdata ({px, py}),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (slot_rdata)
  );

  stwm_ram #(.WIDTH(IDX_W), .DEPTH(NSLOTS)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (nfree[IDX_W-1:0]),
    .wdata (chk_idx),
    .raddr (take[IDX_W-1:0]),
    .rdata (fr_rdata)
  );

  stwm_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .word      (word),
    .free      (out_free),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  assign req_ready = (state == S_IDLE);

  assign sc    = slot_rdata[2*COORD_W-1:COORD_W];
  assign sr    = slot_rdata[COORD_W-1:0];
  assign wlo_x = x0 - HALF_C;
  assign whi_x = x0 + HALF_C;
  assign wlo_y = y0 - HALF_C;
  assign whi_y = y0 + HALF_C;
  assign keep  = vld[chk_idx] && sc >= wlo_x && sc <= whi_x && sr >= wlo_y && sr <= whi_y;
  assign hit   = vld[chk_idx] && sc == x0 && sr == y0;

  assign px      = wlo_x + COORD_W'(dx);
  assign py      = wlo_y + COORD_W'(dy);
  assign old_in  = cen_vld && px >= cen_col - HALF_C && px <= cen_col + HALF_C
                   && py >= cen_row - HALF_C && py <= cen_row + HALF_C;
  assign fresh   = !old_in && take < nfree;
  assign pos_end = dx == OFS_W'(SIDE - 1) && dy == OFS_W'(SIDE - 1);

  assign ovl     = CNT_W'(ox) * CNT_W'(oy);
  assign n_new   = CNT_W'(NSLOTS) - ovl;
  assign n_tot   = (nfree < n_new) ? nfree : n_new;
  assign is_last = CNT_W'(take + CNT_W'(1)) == n_tot;

  assign slot_we = (state == S_EMIT) && out_free;
  assign free_we = (state == S_SCAN) && chk_vld && !keep;
  assign load    = ((state == S_EMIT) || (state == S_LRES)) && out_free;

  always_comb begin
    if (dy == OFS_W'(SIDE - 1)) begin
      dy_next = '0;
      dx_next = dx + OFS_W'(1);
    end else begin
      dy_next = dy + OFS_W'(1);
      dx_next = dx;
    end
  end

  always_comb begin
    if (state == S_LRES) begin
      word.kind    = KIND_LOOKUP;
      word.slot    = SLOT_W'(fslot);
      word.new_col = x0;
      word.new_row = y0;
      word.found   = found_r;
      word.last    = 1'b1;
    end else begin
      word.kind    = KIND_MOVE;
      word.slot    = SLOT_W'(fr_rdata);
      word.new_col = px;
      word.new_row = py;
      word.found   = 1'b0;
      word.last    = is_last;
    end
  end

  // overlap of the old and new window along each axis, and whether the move is ignored
  always_comb begin
    dcol    = (req.tile_col >= cen_col) ? req.tile_col - cen_col : cen_col - req.tile_col;
    drow    = (req.tile_row >= cen_row) ? req.tile_row - cen_row : cen_row - req.tile_row;
    ox_next = (cen_vld && dcol < COORD_W'(SIDE)) ? OV_W'(COORD_W'(SIDE) - dcol) : '0;
    oy_next = (cen_vld && drow < COORD_W'(SIDE)) ? OV_W'(COORD_W'(SIDE) - drow) : '0;
    ignore  = req.tile_col <= HALF_C || req.tile_row <= HALF_C
              || req.tile_col > COORD_MAX - HALF_C || req.tile_row > COORD_MAX - HALF_C
              || (cen_vld && req.tile_col == cen_col && req.tile_row == cen_row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      vld     <= '0;
      cen_col <= '0;
      cen_row <= '0;
      cen_vld <= 1'b0;
      chk_vld <= 1'b0;
      nfree   <= '0;
      take    <= '0;
    end else begin
      if (state == S_SCAN || state == S_LOOK) begin
        if (cnt < CNT_W'(NSLOTS)) begin
          cnt <= cnt + CNT_W'(1);
        end
        chk_vld <= cnt < CNT_W'(NSLOTS);
        chk_idx <= cnt[IDX_W-1:0];
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            x0      <= req.tile_col;
            y0      <= req.tile_row;
            cnt     <= '0;
            chk_vld <= 1'b0;
            nfree   <= '0;
            take    <= '0;
            dx      <= '0;
            dy      <= '0;
            ox      <= ox_next;
            oy      <= oy_next;
            if (req.func == FUNC_LOOKUP) begin
              state <= S_LOOK;
            end else if (!ignore) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (free_we) begin
            nfree <= nfree + CNT_W'(1);
          end
          if (chk_vld && chk_idx == IDX_W'(NSLOTS - 1)) begin
            state <= S_POS;
          end
        end
        S_POS: begin
          if (fresh) begin
            state <= S_EMIT;
          end else if (pos_end) begin
            cen_col <= x0;
            cen_row <= y0;
            cen_vld <= 1'b1;
            state   <= S_IDLE;
          end else begin
            dx <= dx_next;
            dy <= dy_next;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            vld[fr_rdata] <= 1'b1;
            take          <= take + CNT_W'(1);
            if (pos_end) begin
              cen_col <= x0;
              cen_row <= y0;
              cen_vld <= 1'b1;
              state   <= S_IDLE;
            end else begin
              dx    <= dx_next;
              dy    <= dy_next;
              state <= S_POS;
            end
          end
        end
        S_LOOK: begin
          if (chk_vld && (hit || chk_idx == IDX_W'(NSLOTS - 1))) begin
            found_r <= hit;
            fslot   <= hit ? chk_idx : '0;
            state   <= S_LRES;
          end
        end
        S_LRES: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_take_bound: assert property (@(posedge clk) disable iff (rst)
    slot_we |-> take < nfree)
    else $error("slot assigned beyond the freed list");

  a_nfree_bound: assert property (@(posedge clk) disable iff (rst)
    nfree <= CNT_W'(NSLOTS))
    else $error("freed count exceeds slot count");

  a_free_idx: assert property (@(posedge clk) disable iff (rst)
    slot_we |-> fr_rdata < IDX_W'(NSLOTS))
    else $error("freed slot index out of range");

  a_found_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_LRES) && found_r |-> vld[fslot])
    else $error("lookup hit on an unassigned slot");

  a_center_set: assert property (@(posedge clk) disable iff (rst)
    (state == S_POS || state == S_EMIT) ##1 (state == S_IDLE) |-> cen_vld)
    else $error("move finished without a valid centre");

endmodule
